FILE: hw/rtl/mdct_pkg.sv
// shared types and constants for the divisor count tracker
// depends on nothing; used by max_divisor_count_tracker
`timescale 1ns / 1ps

package mdct_pkg;

  // width and saturation limit of a divisor count
  localparam int unsigned COUNT_BITS = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_ACC   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

FILE: hw/rtl/max_divisor_count_tracker.sv
// divisor count tracker top level: trial-division sequencer and best tracking
// depends on mdct_pkg
`timescale 1ns / 1ps

// Each accepted input word carries a candidate and a new-search flag; the block
// counts the candidate's divisors and returns one result word with that count
// and the best number and count since the last search start (ties keep the
// earlier number, zero counts zero). Divisors are tried in pairs for every d
// with d*d <= candidate, each trial running through one shared restoring
// remainder unit at one bit per cycle. The input is not ready while an item is
// in progress; the result waits in an output register until taken.
module max_divisor_count_tracker #(
  parameter int unsigned VALUE_BITS = 17
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input word
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,   // candidate, zero fill
  input  logic [0:0]                            in_tuser,   // new_search
  // result word
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((VALUE_BITS + 2 * mdct_pkg::COUNT_BITS + 7) / 8) * 8-1:0]
                                                out_tdata   // candidate_divisors,
                                                            // best_number,
                                                            // best_divisors, zero fill
);

  localparam int unsigned CB    = mdct_pkg::COUNT_BITS;
  localparam int unsigned OUT_W = ((VALUE_BITS + 2 * CB + 7) / 8) * 8;
  // trial divisor width: holds the first d with d*d above any candidate
  localparam int unsigned DW    = (VALUE_BITS + 1) / 2 + 1;
  // square of the trial divisor
  localparam int unsigned SQW   = VALUE_BITS + 2;
  localparam int unsigned BCW   = $clog2(VALUE_BITS + 1);

  mdct_pkg::state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] nsh_r, nsh_nxt;
  logic [DW-1:0]         d_r, d_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [BCW-1:0]        bit_r, bit_nxt;
  logic [CB-1:0]         cnt_r, cnt_nxt;
  logic [CB-1:0]         best_cnt_r, best_cnt_nxt;
  logic [VALUE_BITS-1:0] best_val_r, best_val_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CB-1:0]         out_cnt_r, out_cnt_nxt;
  logic [VALUE_BITS-1:0] out_bval_r, out_bval_nxt;
  logic [CB-1:0]         out_bcnt_r, out_bcnt_nxt;

  logic                  in_fire;
  logic [DW:0]           rem_sh;
  logic                  rem_ge;
  logic [CB:0]           cnt_sum;
  logic [1:0]            cnt_inc;

  assign in_tready = (state_r == mdct_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // shared remainder step: shift in next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, nsh_r[VALUE_BITS-1]};
  assign rem_ge = (rem_sh >= {1'b0, d_r});

  // pair count: a square root divisor counts once
  assign cnt_inc = (sq_r == {2'b00, n_r}) ? 2'd1 : 2'd2;
  assign cnt_sum = {1'b0, cnt_r} + {{(CB - 1){1'b0}}, cnt_inc};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    nsh_nxt       = nsh_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    best_cnt_nxt  = best_cnt_r;
    best_val_nxt  = best_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cnt_nxt   = out_cnt_r;
    out_bval_nxt  = out_bval_r;
    out_bcnt_nxt  = out_bcnt_r;
    case (state_r)
      mdct_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_nxt   = in_tdata[VALUE_BITS-1:0];
          d_nxt   = {{(DW - 1){1'b0}}, 1'b1};
          sq_nxt  = {{(SQW - 1){1'b0}}, 1'b1};
          cnt_nxt = '0;
          if (in_tuser[0]) begin
            best_cnt_nxt = '0;
            best_val_nxt = '0;
          end
          state_nxt = mdct_pkg::ST_CHECK;
        end
      end
      mdct_pkg::ST_CHECK: begin
        if (sq_r <= {2'b00, n_r}) begin
          nsh_nxt   = n_r;
          rem_nxt   = '0;
          bit_nxt   = BCW'(VALUE_BITS);
          state_nxt = mdct_pkg::ST_DIV;
        end else begin
          state_nxt = mdct_pkg::ST_DONE;
        end
      end
      mdct_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? DW'(rem_sh - {1'b0, d_r}) : rem_sh[DW-1:0];
        nsh_nxt = {nsh_r[VALUE_BITS-2:0], 1'b0};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == BCW'(1)) begin
          state_nxt = mdct_pkg::ST_ACC;
        end
      end
      mdct_pkg::ST_ACC: begin
        // saturating accumulate, then step d and its square
        if (rem_r == '0) begin
          cnt_nxt = cnt_sum[CB] ? mdct_pkg::COUNT_MAX : cnt_sum[CB-1:0];
        end
        d_nxt     = d_r + 1'b1;
        sq_nxt    = sq_r + SQW'({d_r, 1'b1});
        state_nxt = mdct_pkg::ST_CHECK;
      end
      mdct_pkg::ST_DONE: begin
        // hand off once the output register is free
        if (!out_valid_r || out_tready) begin
          if (cnt_r > best_cnt_r) begin
            best_cnt_nxt = cnt_r;
            best_val_nxt = n_r;
            out_bcnt_nxt = cnt_r;
            out_bval_nxt = n_r;
          end else begin
            out_bcnt_nxt = best_cnt_r;
            out_bval_nxt = best_val_r;
          end
          out_cnt_nxt   = cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = mdct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mdct_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      best_cnt_r  <= '0;
      best_val_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      best_cnt_r  <= best_cnt_nxt;
      best_val_r  <= best_val_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    nsh_r      <= nsh_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_bval_r <= out_bval_nxt;
    out_bcnt_r <= out_bcnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_bcnt_r, out_bval_r, out_cnt_r});

  // checks
  a_best_not_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_bcnt_r >= out_cnt_r))
    else $error("best count below candidate count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input ready right after accept");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mdct_pkg::ST_DIV || state_r == mdct_pkg::ST_ACC) |-> (rem_r < d_r))
    else $error("remainder not below divisor");

  a_zero_best: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_bcnt_r == '0) |-> (out_bval_r == '0))
    else $error("best number set with zero count");

endmodule
